// File: hdl/gdb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdb_pkg: shared types, constants and helpers for distance and bearing
// Fixed-point constants (Q2.30 radians), CORDIC arctangent table, and the
// per-step functions used by the pipelines.
// ----------------------------------------------------------------------------
package gdb_pkg;

   localparam int CORDIC_STAGES_DEF = 24;
   localparam int CW                = 36;   // CORDIC datapath width
   localparam int SQRT_STEPS        = 31;   // one result bit per step, radicand < 2^61

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_LAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_LON = 2'd1;

   localparam logic signed [30:0] LAT_MAX  = 31'sd900000000;
   localparam logic signed [31:0] LON_MAX  = 32'sd1800000000;
   localparam logic signed [32:0] LON_FULL = 33'sd3600000000;
   localparam logic [30:0]        RAD_K60  = 31'd2012227627;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sh026DD3B6A;
   localparam logic signed [CW-1:0] HALF_PI     = 36'sh06487ED50;
   localparam logic [30:0]        ONE_Q30  = 31'h4000_0000;
   localparam logic [23:0]        EARTH_M2 = 24'd12742000;
   localparam logic [24:0]        DIST_MAX = 25'd20015087;
   localparam logic [30:0]        CDEG_K18 = 31'd1501974482;
   localparam logic signed [17:0] FULL_CIRCLE = 18'sd36000;

   typedef logic signed [CW-1:0] cw_type;

   typedef enum logic [1:0] {OFF_ZERO, OFF_POS, OFF_NEG} off_type;

   typedef struct packed {
      off_type off;
      logic    zero;
   } brg_tag_type;

   typedef struct packed {
      logic [60:0] n;
      logic [60:0] res;
   } sq_type;

   // arctangent of 2^-i in Q2.30, truncated (rounded up for i = 27 to 30)
   function automatic cw_type atan_entry(input int i);
      cw_type v;
      case (i)
         0:  v = 36'sh03243F6A8;
         1:  v = 36'sh01DAC6705;
         2:  v = 36'sh00FADBAFC;
         3:  v = 36'sh007F56EA6;
         4:  v = 36'sh003FEAB76;
         5:  v = 36'sh001FFD55B;
         6:  v = 36'sh000FFFAAA;
         7:  v = 36'sh0007FFF55;
         8:  v = 36'sh0003FFFEA;
         9:  v = 36'sh0001FFFFD;
         10: v = 36'sh0000FFFFF;
         11: v = 36'sh00007FFFF;
         12: v = 36'sh00003FFFF;
         13: v = 36'sh00001FFFF;
         14: v = 36'sh00000FFFF;
         15: v = 36'sh000007FFF;
         16: v = 36'sh000003FFF;
         17: v = 36'sh000001FFF;
         18: v = 36'sh000000FFF;
         19: v = 36'sh0000007FF;
         20: v = 36'sh0000003FF;
         21: v = 36'sh0000001FF;
         22: v = 36'sh0000000FF;
         23: v = 36'sh00000007F;
         24: v = 36'sh00000003F;
         25: v = 36'sh00000001F;
         26: v = 36'sh00000000F;
         27: v = 36'sh000000008;
         28: v = 36'sh000000004;
         29: v = 36'sh000000002;
         30: v = 36'sh000000001;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q2.30 product, floored
   function automatic logic signed [33:0] mul30(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[63:30];
   endfunction

   // 1e-7 degree to Q2.30 radians; half selects the half angle
   function automatic logic signed [33:0] to_rad(input logic signed [32:0] deg,
                                                 input logic half);
      logic        neg;
      logic [31:0] m;
      logic [62:0] p;
      logic [33:0] r;
      neg = deg[32];
      m   = neg ? 32'(-deg) : deg[31:0];
      p   = 63'(m) * 63'(RAD_K60);
      if (half) begin
         r = 34'((p + 63'(64'd1 << 30)) >> 31);
      end else begin
         r = 34'((p + 63'(64'd1 << 29)) >> 30);
      end
      return neg ? 34'(-r) : r;
   endfunction

   // one step of the floor square root digit recurrence
   function automatic sq_type sqrt_step(input sq_type s, input logic [60:0] b);
      sq_type      o;
      logic [61:0] t;
      t = {1'b0, s.res} + {1'b0, b};
      if ({1'b0, s.n} >= t) begin
         o.n   = s.n - t[60:0];
         o.res = (s.res >> 1) + b;
      end else begin
         o.n   = s.n;
         o.res = s.res >> 1;
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// File: hdl/gps_distance_and_bearing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gps_distance_and_bearing: haversine distance and initial bearing pipeline
// Throughput is one position per cycle, fixed by the pipeline.
// The receiver cannot stall, so busy stays low. Synchronous reset clears the
// valid bits of every stage and zeroes both destination registers.
// ----------------------------------------------------------------------------
module gps_distance_and_bearing #(
   parameter int CORDIC_STAGES = gdb_pkg::CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [30:0]            req_car_lat,
   input  logic signed [31:0]            req_car_lon,
   output logic                          rsp_valid,
   output logic [24:0]                   rsp_distance_m,
   output logic [15:0]                   rsp_bearing_centideg,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gdb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int LATENCY = 40 + 2 * CORDIC_STAGES;
   localparam int SQ      = gdb_pkg::SQRT_STEPS;
   localparam int CW      = gdb_pkg::CW;

   // The pipeline never backs up: every beat moves one stage per cycle.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // ---------------------------------------------------------------- CSRs --
   logic signed [30:0] dest_lat_ff;
   logic signed [31:0] dest_lon_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_lat_ff <= '0;
         dest_lon_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gdb_pkg::CSR_DEST_LAT: dest_lat_ff <= $signed(csr_wdata[30:0]);
            gdb_pkg::CSR_DEST_LON: dest_lon_ff <= $signed(csr_wdata);
            default: ; // drop writes to unknown registers
         endcase
      end
   end

   // ------------------------------------------------ S0: clamp coordinates --
   logic               s0_valid_ff;
   logic signed [30:0] lat1_ff, lat2_ff;
   logic signed [31:0] lon1_ff, lon2_ff;
   logic signed [30:0] lat1_in, lat2_in;
   logic signed [31:0] lon1_in, lon2_in;

   always_comb begin
      lat1_in = (req_car_lat > gdb_pkg::LAT_MAX)  ? gdb_pkg::LAT_MAX :
                (req_car_lat < -gdb_pkg::LAT_MAX) ? -gdb_pkg::LAT_MAX : req_car_lat;
      lat2_in = (dest_lat_ff > gdb_pkg::LAT_MAX)  ? gdb_pkg::LAT_MAX :
                (dest_lat_ff < -gdb_pkg::LAT_MAX) ? -gdb_pkg::LAT_MAX : dest_lat_ff;
      lon1_in = (req_car_lon > gdb_pkg::LON_MAX)  ? gdb_pkg::LON_MAX :
                (req_car_lon < -gdb_pkg::LON_MAX) ? -gdb_pkg::LON_MAX : req_car_lon;
      lon2_in = (dest_lon_ff > gdb_pkg::LON_MAX)  ? gdb_pkg::LON_MAX :
                (dest_lon_ff < -gdb_pkg::LON_MAX) ? -gdb_pkg::LON_MAX : dest_lon_ff;
   end

   always_ff @(posedge clock) begin
      lat1_ff <= lat1_in;
      lat2_ff <= lat2_in;
      lon1_ff <= lon1_in;
      lon2_ff <= lon2_in;
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start && !busy;
      end
   end

   // --------------------------------------------- S1: differences and wrap --
   logic               s1_valid_ff, flip_ff, flip_in;
   logic signed [30:0] s1_lat1_ff, s1_lat2_ff;
   logic signed [32:0] dlat_ff, dlon_ff, rlon_ff;
   logic signed [32:0] dlat_in, dlon_in, rlon_in, dlon_raw;

   always_comb begin
      dlon_raw = 33'(lon2_ff) - 33'(lon1_ff);
      dlat_in  = 33'(lat1_ff) - 33'(lat2_ff);
      // wrap the longitude step into +-180 degrees
      if (dlon_raw > 33'(gdb_pkg::LON_MAX)) begin
         dlon_in = dlon_raw - gdb_pkg::LON_FULL;
      end else if (dlon_raw < -33'(gdb_pkg::LON_MAX)) begin
         dlon_in = dlon_raw + gdb_pkg::LON_FULL;
      end else begin
         dlon_in = dlon_raw;
      end
      // fold beyond +-90 degrees by half a turn; sin and cos flip sign
      if (dlon_in > 33'(gdb_pkg::LAT_MAX)) begin
         rlon_in = dlon_in - 33'(gdb_pkg::LON_MAX);
         flip_in = 1'b1;
      end else if (dlon_in < -33'(gdb_pkg::LAT_MAX)) begin
         rlon_in = dlon_in + 33'(gdb_pkg::LON_MAX);
         flip_in = 1'b1;
      end else begin
         rlon_in = dlon_in;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_lat1_ff <= lat1_ff;
      s1_lat2_ff <= lat2_ff;
      dlat_ff    <= dlat_in;
      dlon_ff    <= dlon_in;
      rlon_ff    <= rlon_in;
      flip_ff    <= flip_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   // ------------------------------------------------- S2: degrees to radians --
   logic               s2_valid_ff, s2_flip_ff;
   logic signed [33:0] th_lat1_ff, th_lat2_ff, th_dlat_ff, th_dlon_ff, th_r_ff;

   always_ff @(posedge clock) begin
      th_lat1_ff <= gdb_pkg::to_rad(33'(s1_lat1_ff), 1'b0);
      th_lat2_ff <= gdb_pkg::to_rad(33'(s1_lat2_ff), 1'b0);
      th_dlat_ff <= gdb_pkg::to_rad(dlat_ff, 1'b1);
      th_dlon_ff <= gdb_pkg::to_rad(dlon_ff, 1'b1);
      th_r_ff    <= gdb_pkg::to_rad(rlon_ff, 1'b0);
      s2_flip_ff <= flip_ff;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // ------------------------------------------------- sin/cos CORDIC bank --
   gdb_pkg::cw_type s1_y, c1_x, s2_y, c2_x, sh_y, sg_y, sd_y, cd_x;
   logic            rot_valid, rot_flip;

   gdb_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1), .VECTOR(1'b0)) u_rot_lat1 (
      .clock, .reset, .valid_i(s2_valid_ff),
      .x_i(gdb_pkg::CORDIC_GAIN), .y_i('0), .z_i(CW'(th_lat1_ff)), .tag_i(1'b0),
      .valid_o(), .x_o(c1_x), .y_o(s1_y), .z_o(), .tag_o());

   gdb_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1), .VECTOR(1'b0)) u_rot_lat2 (
      .clock, .reset, .valid_i(s2_valid_ff),
      .x_i(gdb_pkg::CORDIC_GAIN), .y_i('0), .z_i(CW'(th_lat2_ff)), .tag_i(1'b0),
      .valid_o(), .x_o(c2_x), .y_o(s2_y), .z_o(), .tag_o());

   gdb_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1), .VECTOR(1'b0)) u_rot_dlat (
      .clock, .reset, .valid_i(s2_valid_ff),
      .x_i(gdb_pkg::CORDIC_GAIN), .y_i('0), .z_i(CW'(th_dlat_ff)), .tag_i(1'b0),
      .valid_o(), .x_o(), .y_o(sh_y), .z_o(), .tag_o());

   gdb_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1), .VECTOR(1'b0)) u_rot_dlon (
      .clock, .reset, .valid_i(s2_valid_ff),
      .x_i(gdb_pkg::CORDIC_GAIN), .y_i('0), .z_i(CW'(th_dlon_ff)), .tag_i(1'b0),
      .valid_o(), .x_o(), .y_o(sg_y), .z_o(), .tag_o());

   gdb_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1), .VECTOR(1'b0)) u_rot_brg (
      .clock, .reset, .valid_i(s2_valid_ff),
      .x_i(gdb_pkg::CORDIC_GAIN), .y_i('0), .z_i(CW'(th_r_ff)), .tag_i(s2_flip_ff),
      .valid_o(rot_valid), .x_o(cd_x), .y_o(sd_y), .z_o(), .tag_o(rot_flip));

   // ------------------------------------------------ SA: first products --
   logic               sa_valid_ff;
   logic signed [33:0] sh2_ff, c1c2_ff, sg2_ff, c2sd_ff, c1s2_ff, s1c2_ff;
   logic signed [31:0] cdf_ff;
   logic signed [31:0] sdf_w, cdf_w;

   // trig results stay within about 2^30, so 32 bits carry them exactly
   always_comb begin
      sdf_w = rot_flip ? -$signed(sd_y[31:0]) : $signed(sd_y[31:0]);
      cdf_w = rot_flip ? -$signed(cd_x[31:0]) : $signed(cd_x[31:0]);
   end

   always_ff @(posedge clock) begin
      sh2_ff  <= gdb_pkg::mul30($signed(sh_y[31:0]), $signed(sh_y[31:0]));
      c1c2_ff <= gdb_pkg::mul30($signed(c1_x[31:0]), $signed(c2_x[31:0]));
      sg2_ff  <= gdb_pkg::mul30($signed(sg_y[31:0]), $signed(sg_y[31:0]));
      c2sd_ff <= gdb_pkg::mul30($signed(c2_x[31:0]), sdf_w);
      c1s2_ff <= gdb_pkg::mul30($signed(c1_x[31:0]), $signed(s2_y[31:0]));
      s1c2_ff <= gdb_pkg::mul30($signed(s1_y[31:0]), $signed(c2_x[31:0]));
      cdf_ff  <= cdf_w;
      if (reset) begin
         sa_valid_ff <= 1'b0;
      end else begin
         sa_valid_ff <= rot_valid;
      end
   end

   // ----------------------------------------------- SB: second products --
   logic               sb_valid_ff;
   logic signed [33:0] sb_sh2_ff, q_ff, t_ff, bx_sb_ff, c1s2_sb_ff;

   always_ff @(posedge clock) begin
      sb_sh2_ff  <= sh2_ff;
      q_ff       <= gdb_pkg::mul30($signed(c1c2_ff[31:0]), $signed(sg2_ff[31:0]));
      t_ff       <= gdb_pkg::mul30($signed(s1c2_ff[31:0]), cdf_ff);
      bx_sb_ff   <= c2sd_ff;
      c1s2_sb_ff <= c1s2_ff;
      if (reset) begin
         sb_valid_ff <= 1'b0;
      end else begin
         sb_valid_ff <= sa_valid_ff;
      end
   end

   // ------------------------------------- SC: haversine a and bearing terms --
   logic               sc_valid_ff;
   logic [30:0]        a_ff, a_in;
   logic signed [33:0] bx_ff;
   logic signed [34:0] by_ff;
   logic signed [34:0] a_sum;

   always_comb begin
      a_sum = 35'(sb_sh2_ff) + 35'(q_ff);
      // hold a inside [0, 1]
      if (a_sum[34]) begin
         a_in = '0;
      end else if (a_sum > 35'(gdb_pkg::ONE_Q30)) begin
         a_in = gdb_pkg::ONE_Q30;
      end else begin
         a_in = a_sum[30:0];
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      bx_ff <= bx_sb_ff;
      by_ff <= 35'(c1s2_sb_ff) - 35'(t_ff);
      if (reset) begin
         sc_valid_ff <= 1'b0;
      end else begin
         sc_valid_ff <= sb_valid_ff;
      end
   end

   // ------------------------------------------ square roots, one bit a stage --
   // sqrt(a) and sqrt(1-a) run side by side; the bearing operands, already
   // folded into the right half plane, ride along.
   gdb_pkg::cw_type      bnum0, bden0;
   gdb_pkg::brg_tag_type btag0;
   gdb_pkg::cw_type      bx_e, by_e;

   always_comb begin
      bx_e       = CW'(bx_ff);
      by_e       = CW'(by_ff);
      btag0.zero = (bx_ff == '0) && (by_ff == '0);
      if (!by_e[CW-1]) begin
         bnum0     = bx_e;
         bden0     = by_e;
         btag0.off = gdb_pkg::OFF_ZERO;
      end else if (!bx_e[CW-1]) begin
         bnum0     = -by_e;
         bden0     = bx_e;
         btag0.off = gdb_pkg::OFF_POS;
      end else begin
         bnum0     = by_e;
         bden0     = -bx_e;
         btag0.off = gdb_pkg::OFF_NEG;
      end
   end

   logic                 sq_valid_ff [SQ], sq_valid_prev [SQ];
   gdb_pkg::sq_type      sqa_ff [SQ], sqa_prev [SQ], sqb_ff [SQ], sqb_prev [SQ];
   gdb_pkg::cw_type      bnum_ff [SQ], bnum_prev [SQ], bden_ff [SQ], bden_prev [SQ];
   gdb_pkg::brg_tag_type btag_ff [SQ], btag_prev [SQ];

   always_comb begin
      sq_valid_prev[0] = sc_valid_ff;
      sqa_prev[0].n    = {a_ff, 30'b0};
      sqa_prev[0].res  = '0;
      sqb_prev[0].n    = {gdb_pkg::ONE_Q30 - a_ff, 30'b0};
      sqb_prev[0].res  = '0;
      bnum_prev[0]     = bnum0;
      bden_prev[0]     = bden0;
      btag_prev[0]     = btag0;
      for (int k = 1; k < SQ; k++) begin
         sq_valid_prev[k] = sq_valid_ff[k-1];
         sqa_prev[k]      = sqa_ff[k-1];
         sqb_prev[k]      = sqb_ff[k-1];
         bnum_prev[k]     = bnum_ff[k-1];
         bden_prev[k]     = bden_ff[k-1];
         btag_prev[k]     = btag_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SQ; k++) begin
         sqa_ff[k]  <= gdb_pkg::sqrt_step(sqa_prev[k], 61'(1) << (60 - 2 * k));
         sqb_ff[k]  <= gdb_pkg::sqrt_step(sqb_prev[k], 61'(1) << (60 - 2 * k));
         bnum_ff[k] <= bnum_prev[k];
         bden_ff[k] <= bden_prev[k];
         btag_ff[k] <= btag_prev[k];
      end
      if (reset) begin
         for (int k = 0; k < SQ; k++) begin
            sq_valid_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < SQ; k++) begin
            sq_valid_ff[k] <= sq_valid_prev[k];
         end
      end
   end

   // ------------------------------------------------- atan2 CORDIC pair --
   gdb_pkg::cw_type      zd_w, zb_w;
   logic                 vec_valid;
   logic [$bits(gdb_pkg::brg_tag_type)-1:0] vtag_w;
   gdb_pkg::brg_tag_type vtag;

   gdb_cordic #(.STAGES(CORDIC_STAGES), .TAG_W(1), .VECTOR(1'b1)) u_vec_dist (
      .clock, .reset, .valid_i(sq_valid_ff[SQ-1]),
      .x_i(CW'(sqb_ff[SQ-1].res[30:0])), .y_i(CW'(sqa_ff[SQ-1].res[30:0])),
      .z_i('0), .tag_i(1'b0),
      .valid_o(), .x_o(), .y_o(), .z_o(zd_w), .tag_o());

   gdb_cordic #(.STAGES(CORDIC_STAGES), .TAG_W($bits(gdb_pkg::brg_tag_type)),
                .VECTOR(1'b1)) u_vec_brg (
      .clock, .reset, .valid_i(sq_valid_ff[SQ-1]),
      .x_i(bden_ff[SQ-1]), .y_i(bnum_ff[SQ-1]), .z_i('0), .tag_i(btag_ff[SQ-1]),
      .valid_o(vec_valid), .x_o(), .y_o(), .z_o(zb_w), .tag_o(vtag_w));

   assign vtag = gdb_pkg::brg_tag_type'(vtag_w);

   // ------------------------------------- F1: scale distance, full angle --
   logic            f1_valid_ff, f1_neg_ff, f1_zero_ff;
   logic [54:0]     prod_d_ff;
   logic [31:0]     mag_ff;
   logic [30:0]     zd_clip;
   gdb_pkg::cw_type off_v, th_v, th_abs;

   always_comb begin
      zd_clip = zd_w[CW-1] ? '0 : zd_w[30:0];
      unique case (vtag.off)
         gdb_pkg::OFF_POS: off_v = gdb_pkg::HALF_PI;
         gdb_pkg::OFF_NEG: off_v = -gdb_pkg::HALF_PI;
         default:          off_v = '0;
      endcase
      th_v   = off_v + zb_w;
      th_abs = th_v[CW-1] ? -th_v : th_v;
   end

   always_ff @(posedge clock) begin
      prod_d_ff  <= 55'(zd_clip) * 55'(gdb_pkg::EARTH_M2);
      mag_ff     <= th_abs[31:0];
      f1_neg_ff  <= th_v[CW-1];
      f1_zero_ff <= vtag.zero;
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= vec_valid;
      end
   end

   // --------------------------------- F2: round distance, to centidegrees --
   logic        f2_valid_ff, f2_neg_ff, f2_zero_ff;
   logic [24:0] dist_ff, dist_in;
   logic [15:0] cdeg_ff;
   logic [54:0] dsum;
   logic [62:0] bprod;

   always_comb begin
      dsum  = prod_d_ff + 55'(64'd1 << 29);
      // saturate at half the circumference
      dist_in = (dsum[54:30] > gdb_pkg::DIST_MAX) ? gdb_pkg::DIST_MAX : dsum[54:30];
      bprod = 63'(mag_ff) * 63'(gdb_pkg::CDEG_K18) + 63'(64'd1 << 47);
   end

   always_ff @(posedge clock) begin
      dist_ff    <= dist_in;
      cdeg_ff    <= 16'(bprod[62:48]);
      f2_neg_ff  <= f1_neg_ff;
      f2_zero_ff <= f1_zero_ff;
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   // ---------------------------------- F3: wrap bearing, output register --
   logic               rsp_valid_ff;
   logic [24:0]        rsp_dist_ff;
   logic [15:0]        rsp_brg_ff, brg_in;
   logic signed [17:0] v0, v1, v2, v3;

   always_comb begin
      v0 = f2_neg_ff ? -$signed({2'b0, cdeg_ff}) : $signed({2'b0, cdeg_ff});
      v1 = v0[17] ? v0 + gdb_pkg::FULL_CIRCLE : v0;
      v2 = (v1 >= gdb_pkg::FULL_CIRCLE) ? v1 - gdb_pkg::FULL_CIRCLE : v1;
      v3 = v2[17] ? '0 : v2;
      // no bearing exists for coincident points or a pole
      brg_in = f2_zero_ff ? '0 : v3[15:0];
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= dist_ff;
      rsp_brg_ff  <= brg_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f2_valid_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_distance_m       = rsp_dist_ff;
   assign rsp_bearing_centideg = rsp_brg_ff;

   // ---------------------------------------------------------- assertions --
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted beat did not produce a result on time");

   a_brg_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_bearing_centideg < 16'd36000))
      else $error("bearing out of range");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_distance_m <= gdb_pkg::DIST_MAX))
      else $error("distance above saturation limit");

endmodule
`default_nettype wire

// File: hdl/gdb_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdb_cordic: fully pipelined CORDIC, one micro-rotation per stage
// Rotation mode drives z to zero; vectoring mode drives y to zero.
// A tag word travels alongside each beat.
// ----------------------------------------------------------------------------
module gdb_cordic #(
   parameter int STAGES = gdb_pkg::CORDIC_STAGES_DEF,
   parameter int TAG_W  = 1,
   parameter bit VECTOR = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_i,
   input  gdb_pkg::cw_type      x_i,
   input  gdb_pkg::cw_type      y_i,
   input  gdb_pkg::cw_type      z_i,
   input  logic [TAG_W-1:0]     tag_i,
   output logic                 valid_o,
   output gdb_pkg::cw_type      x_o,
   output gdb_pkg::cw_type      y_o,
   output gdb_pkg::cw_type      z_o,
   output logic [TAG_W-1:0]     tag_o
);

   logic             valid_ff   [STAGES];
   logic             valid_prev [STAGES];
   gdb_pkg::cw_type  x_ff [STAGES], y_ff [STAGES], z_ff [STAGES];
   gdb_pkg::cw_type  x_in [STAGES], y_in [STAGES], z_in [STAGES];
   gdb_pkg::cw_type  x_prev [STAGES], y_prev [STAGES], z_prev [STAGES];
   logic [TAG_W-1:0] tag_ff [STAGES], tag_prev [STAGES];

   always_comb begin
      valid_prev[0] = valid_i;
      x_prev[0]     = x_i;
      y_prev[0]     = y_i;
      z_prev[0]     = z_i;
      tag_prev[0]   = tag_i;
      for (int k = 1; k < STAGES; k++) begin
         valid_prev[k] = valid_ff[k-1];
         x_prev[k]     = x_ff[k-1];
         y_prev[k]     = y_ff[k-1];
         z_prev[k]     = z_ff[k-1];
         tag_prev[k]   = tag_ff[k-1];
      end
   end

   always_comb begin
      logic pos;
      for (int k = 0; k < STAGES; k++) begin
         // rotate positive: z still positive, or y not yet above zero
         pos = VECTOR ? (y_prev[k][gdb_pkg::CW-1] || (y_prev[k] == '0))
                      : !z_prev[k][gdb_pkg::CW-1];
         if (pos) begin
            x_in[k] = x_prev[k] - (y_prev[k] >>> k);
            y_in[k] = y_prev[k] + (x_prev[k] >>> k);
            z_in[k] = z_prev[k] - gdb_pkg::atan_entry(k);
         end else begin
            x_in[k] = x_prev[k] + (y_prev[k] >>> k);
            y_in[k] = y_prev[k] - (x_prev[k] >>> k);
            z_in[k] = z_prev[k] + gdb_pkg::atan_entry(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         x_ff[k]   <= x_in[k];
         y_ff[k]   <= y_in[k];
         z_ff[k]   <= z_in[k];
         tag_ff[k] <= tag_prev[k];
      end
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            valid_ff[k] <= valid_prev[k];
         end
      end
   end

   assign valid_o = valid_ff[STAGES-1];
   assign x_o     = x_ff[STAGES-1];
   assign y_o     = y_ff[STAGES-1];
   assign z_o     = z_ff[STAGES-1];
   assign tag_o   = tag_ff[STAGES-1];

endmodule
`default_nettype wire
